### hdl/wsfd_pkg.sv
package wsfd_pkg;

    // result kinds as they appear on the output channel
    typedef enum logic [1:0] {
        KIND_HDR  = 2'd0,
        KIND_DATA = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    localparam logic [3:0] OPCODE_CLOSE   = 4'h8;
    localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
    localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;
    localparam logic [1:0] KEY_STEP_LAST  = 2'd3;

    // one classified byte, ready for the back end to turn into a result
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  first_header;
        logic        mask_on;
        logic [15:0] length;
        logic [7:0]  raw_byte;
        logic [31:0] key_bytes;
        logic [1:0]  key_index;
        logic        last;
    } t_cmd;

endpackage

### hdl/wsfd_in_if.sv
interface wsfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

### hdl/wsfd_out_if.sv
interface wsfd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic        fin_flag;
    logic [2:0]  reserved_bits;
    logic [3:0]  frame_opcode;
    logic        is_close;
    logic        was_masked;
    logic [15:0] payload_length;
    logic [7:0]  data_byte;
    logic        last;

    modport source (
        output valid, input ready,
        output kind, output fin_flag, output reserved_bits, output frame_opcode,
        output is_close, output was_masked, output payload_length,
        output data_byte, output last
    );
    modport sink (
        input valid, output ready,
        input kind, input fin_flag, input reserved_bits, input frame_opcode,
        input is_close, input was_masked, input payload_length,
        input data_byte, input last
    );
endinterface

### hdl/wsfd_front.sv
module wsfd_front
    import wsfd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    wsfd_in_if.sink i_rx,
    input  logic    i_full,
    output logic    o_push,
    output t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        PH_HDR0   = 3'd0,
        PH_HDR1   = 3'd1,
        PH_EXTLEN = 3'd2,
        PH_KEY    = 3'd3,
        PH_DATA   = 3'd4
    } t_phase;

    t_phase      r_phase,        n_phase;
    logic [7:0]  r_first_header, n_first_header;
    logic        r_mask_on,      n_mask_on;
    logic [15:0] r_frame_length, n_frame_length;
    logic [31:0] r_key_bytes,    n_key_bytes;
    logic [15:0] r_byte_count,   n_byte_count;
    logic [1:0]  r_header_step,  n_header_step;

    logic        w_accept;
    logic [7:0]  w_b;
    logic [6:0]  w_code;
    logic [15:0] w_ext_len;
    logic        w_hdr_done;
    logic [15:0] w_hdr_len;
    logic        w_fin;

    assign i_rx.ready = !i_full;
    assign w_accept   = i_rx.valid && !i_full;
    assign w_b        = i_rx.rx_byte;
    assign w_code     = w_b[6:0];
    assign w_ext_len  = {r_frame_length[7:0], w_b};
    assign w_fin      = ({1'b0, r_byte_count} + 17'd1) >= {1'b0, r_frame_length};

    always_comb begin
        n_phase        = r_phase;
        n_first_header = r_first_header;
        n_mask_on      = r_mask_on;
        n_frame_length = r_frame_length;
        n_key_bytes    = r_key_bytes;
        n_byte_count   = r_byte_count;
        n_header_step  = r_header_step;
        w_hdr_done     = 1'b0;
        w_hdr_len      = r_frame_length;
        o_push         = 1'b0;
        o_cmd.kind         = KIND_HDR;
        o_cmd.first_header = r_first_header;
        o_cmd.length       = r_frame_length;
        o_cmd.raw_byte     = w_b;
        o_cmd.key_bytes    = r_key_bytes;
        o_cmd.key_index    = r_byte_count[1:0];
        o_cmd.last         = 1'b0;

        if (w_accept) begin
            case (r_phase)
                PH_HDR1: begin
                    n_mask_on = w_b[7];
                    if (w_code == LEN_CODE_EXT64) begin
                        // unsupported 64-bit length, flag and resync
                        o_push       = 1'b1;
                        o_cmd.kind   = KIND_ERR;
                        o_cmd.length = '0;
                        o_cmd.last   = 1'b1;
                        n_phase      = PH_HDR0;
                    end else if (w_code == LEN_CODE_EXT16) begin
                        n_frame_length = '0;
                        n_header_step  = '0;
                        n_phase        = PH_EXTLEN;
                    end else begin
                        n_frame_length = {9'd0, w_code};
                        n_header_step  = '0;
                        n_key_bytes    = '0;
                        if (w_b[7]) begin
                            n_phase = PH_KEY;
                        end else begin
                            w_hdr_done = 1'b1;
                            w_hdr_len  = {9'd0, w_code};
                        end
                    end
                end
                PH_EXTLEN: begin
                    n_frame_length = w_ext_len;
                    if (r_header_step == 2'd0) begin
                        n_header_step = 2'd1;
                    end else begin
                        n_header_step = '0;
                        n_key_bytes   = '0;
                        if (r_mask_on) begin
                            n_phase = PH_KEY;
                        end else begin
                            w_hdr_done = 1'b1;
                            w_hdr_len  = w_ext_len;
                        end
                    end
                end
                PH_KEY: begin
                    n_key_bytes = {r_key_bytes[23:0], w_b};
                    if (r_header_step != KEY_STEP_LAST) begin
                        n_header_step = r_header_step + 2'd1;
                    end else begin
                        n_header_step = '0;
                        w_hdr_done    = 1'b1;
                        w_hdr_len     = r_frame_length;
                    end
                end
                PH_DATA: begin
                    o_push       = 1'b1;
                    o_cmd.kind   = KIND_DATA;
                    o_cmd.last   = w_fin;
                    n_byte_count = r_byte_count + 16'd1;
                    if (w_fin) begin
                        n_phase = PH_HDR0;
                    end
                end
                default: begin
                    n_first_header = w_b;
                    n_mask_on      = 1'b0;
                    n_frame_length = '0;
                    n_key_bytes    = '0;
                    n_byte_count   = '0;
                    n_header_step  = '0;
                    n_phase        = PH_HDR1;
                end
            endcase

            if (w_hdr_done) begin
                o_push       = 1'b1;
                o_cmd.kind   = KIND_HDR;
                o_cmd.length = w_hdr_len;
                o_cmd.last   = (w_hdr_len == 16'd0);
                n_byte_count = '0;
                n_phase      = (w_hdr_len == 16'd0) ? PH_HDR0 : PH_DATA;
            end
        end
        o_cmd.mask_on = n_mask_on;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HDR0;
            r_first_header <= '0;
            r_mask_on      <= 1'b0;
            r_frame_length <= '0;
            r_key_bytes    <= '0;
            r_byte_count   <= '0;
            r_header_step  <= '0;
        end else begin
            r_phase        <= n_phase;
            r_first_header <= n_first_header;
            r_mask_on      <= n_mask_on;
            r_frame_length <= n_frame_length;
            r_key_bytes    <= n_key_bytes;
            r_byte_count   <= n_byte_count;
            r_header_step  <= n_header_step;
        end
    end

endmodule

### hdl/wsfd_queue.sv
module wsfd_queue
    import wsfd_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF,
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  t_cmd             i_cmd,
    input  logic             i_pop,
    output t_cmd             o_head,
    output logic             o_full,
    output logic             o_empty,
    output logic [CNT_W-1:0] o_level
);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_level,  n_level;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_level == CNT_W'(DEPTH));
    assign o_empty   = (r_level == '0);
    assign o_level   = r_level;
    assign o_head    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_level  = r_level;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (w_do_push && !w_do_pop) begin
            n_level = r_level + CNT_W'(1);
        end else if (w_do_pop && !w_do_push) begin
            n_level = r_level - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_level  <= n_level;
        end
    end

endmodule

### hdl/wsfd_back.sv
module wsfd_back
    import wsfd_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_empty,
    input  t_cmd         i_head,
    output logic         o_pop,
    wsfd_out_if.source   o_res
);

    logic        r_valid;
    logic [1:0]  r_kind;
    logic [7:0]  r_first_header;
    logic        r_mask_on;
    logic [15:0] r_length;
    logic [7:0]  r_data;
    logic        r_last;
    logic [7:0]  w_key;
    logic [7:0]  w_data;

    // key byte 0 is the first one received, held in the top byte
    always_comb begin
        case (i_head.key_index)
            2'd0:    w_key = i_head.key_bytes[31:24];
            2'd1:    w_key = i_head.key_bytes[23:16];
            2'd2:    w_key = i_head.key_bytes[15:8];
            default: w_key = i_head.key_bytes[7:0];
        endcase
        case (i_head.kind)
            KIND_DATA: w_data = i_head.raw_byte ^ w_key;
            default:   w_data = '0;
        endcase
    end

    assign o_pop = !i_empty && (!r_valid || o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind         <= i_head.kind;
            r_first_header <= i_head.first_header;
            r_mask_on      <= i_head.mask_on;
            r_length       <= i_head.length;
            r_data         <= w_data;
            r_last         <= i_head.last;
        end
    end

    assign o_res.valid          = r_valid;
    assign o_res.kind           = r_kind;
    assign o_res.fin_flag       = r_first_header[7];
    assign o_res.reserved_bits  = r_first_header[6:4];
    assign o_res.frame_opcode   = r_first_header[3:0];
    assign o_res.is_close       = (r_first_header[3:0] == OPCODE_CLOSE);
    assign o_res.was_masked     = r_mask_on;
    assign o_res.payload_length = r_length;
    assign o_res.data_byte      = r_data;
    assign o_res.last           = r_last;

endmodule

### hdl/websocket_frame_deframer_top.sv
// channel  | dir | handshake          | payload
// ---------+-----+--------------------+---------------------------------------------
// i_rx     | in  | valid/ready        | rx_byte
// o_res    | out | valid/ready        | kind, fin_flag, reserved_bits, frame_opcode,
//          |     |                    | is_close, was_masked, payload_length,
//          |     |                    | data_byte, last
//
// one byte per cycle sustained while the queue has room; a result passes from the front
// parse into a queue entry and then into the back output register
// header bytes that finish nothing produce no result and never touch the queue
// a stalled output fills the queue; the input stalls while the queue holds
// QUEUE_DEPTH entries, with one more result waiting in the output register
// synchronous active-low reset clears the parse state, queue pointers and output valid
module websocket_frame_deframer_top
    import wsfd_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    localparam int unsigned LVL_W = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wsfd_in_if.sink    i_rx,
    wsfd_out_if.source o_res
);

    // front to queue
    logic             w_push;
    t_cmd             w_push_cmd;
    logic             w_full;
    // queue to back
    logic             w_pop;
    t_cmd             w_head;
    logic             w_empty;
    logic [LVL_W-1:0] w_level;

    // front: header parsing, length and key capture, byte classification
    wsfd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_cmd   (w_push_cmd)
    );

    // short queue so that output stalls do not block parsing right away
    wsfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_level (w_level)
    );

    // back: unmasking and the output register
    wsfd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_res   (o_res)
    );

`ifndef SYNTHESIS
    // the front only writes the queue when it has taken a byte, which needs room
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("queue written while full");

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_level <= LVL_W'(QUEUE_DEPTH))
        else $error("queue level above depth");

    // an unsupported length always closes the frame
    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.kind == KIND_ERR) |-> (o_res.last && o_res.payload_length == '0))
        else $error("error result not marked last");

    // payload bytes only exist for frames of nonzero length
    a_data_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.kind == KIND_DATA) |-> (o_res.payload_length != '0))
        else $error("payload byte on empty frame");
`endif

endmodule
